// ===== src/sts_pkg.sv =====
package sts_pkg;

    typedef enum logic [3:0] {
        K_IDENT    = 4'd0,
        K_FALSE    = 4'd1,
        K_TRUE     = 4'd2,
        K_STRING   = 4'd3,
        K_LPAREN   = 4'd4,
        K_RPAREN   = 4'd5,
        K_QUOTE    = 4'd6,
        K_BACKTICK = 4'd7,
        K_COMMA    = 4'd8,
        K_COMMA_AT = 4'd9,
        K_EOF      = 4'd10,
        K_ERROR    = 4'd11
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE     = 2'd0,
        E_BAD_CHAR = 2'd1,
        E_OPEN_STR = 2'd2
    } t_err;

    typedef struct packed {
        logic        last;
        t_err        err;
        logic [31:0] length;
        logic [31:0] start;
        t_kind       kind;
    } t_token;

    // Up to two tokens produced by one input word, in delivery order
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    localparam int unsigned OUT_DATA_BITS = 72;
    localparam int unsigned FIFO_DEPTH    = 4;

    localparam logic [31:0] SPAN_MAX = 32'hFFFF_FFFF;

    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_BTICK   = 8'h60;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_spec(input logic [7:0] c);
        return (c == 8'h21) || (c == 8'h24) || (c == 8'h25) || (c == 8'h26) ||
               (c == 8'h2A) || (c == 8'h2F) || (c == 8'h3A) || (c == 8'h3C) ||
               (c == 8'h3D) || (c == 8'h3E) || (c == 8'h3F) || (c == 8'h5E) ||
               (c == 8'h5F) || (c == 8'h7E);
    endfunction

    function automatic logic is_init(input logic [7:0] c);
        return is_alpha(c) || is_spec(c);
    endfunction

    function automatic logic is_subs(input logic [7:0] c);
        return is_init(c) || (c >= 8'h30 && c <= 8'h39) || (c == 8'h2B) ||
               (c == 8'h2D) || (c == 8'h2E) || (c == CH_AT);
    endfunction

endpackage

// ===== src/scheme_token_scanner_core.sv =====
// Channel    Direction  Contents
// s_axis     in         tdata: char_code; tuser: end_flag
// m_axis     out        tdata: token_kind, token_start, token_length, error_code; tlast: last_flag
//
// One input word is scanned per cycle while s_axis tready is high; its tokens are
// registered into a four-entry output queue and leave it one per cycle while m_axis tready is high.
// A word that yields two tokens (flushed identifier or comma, or end of input with a
// token still open) fills two queue slots, so the input stalls while
// the queue has under two free slots.
// Synchronous active-low reset clears the scanner state and the queue.
// Stalls on m_axis back up through the queue into s_axis tready.
module scheme_token_scanner_core #(
    parameter int unsigned POSITION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tuser,   // [0] end_flag
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [3:0] kind, [35:4] start, [67:36] length, [69:68] error
    output logic        o_m_axis_tlast    // last_flag
);
    import sts_pkg::*;

    logic   accept;
    logic   room;
    t_push  push;
    t_token tok;

    assign o_s_axis_tready = room;
    assign accept          = i_s_axis_tvalid && room;

    sts_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_s_axis_tdata),
        .i_end    (i_s_axis_tuser),
        .o_push   (push)
    );

    sts_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_axis_tready),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .o_tok   (tok)
    );

    assign o_m_axis_tdata = OUT_DATA_BITS'({tok.err, tok.length, tok.start, tok.kind});
    assign o_m_axis_tlast = tok.last;

endmodule

// ===== src/sts_scan.sv =====
module sts_scan #(
    parameter int unsigned POSITION_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_char,
    input  logic          i_end,
    output sts_pkg::t_push o_push
);
    import sts_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE, M_COMMENT, M_IDENT, M_BAR, M_HASH, M_STRING, M_COMMA, M_DONE
    } t_mode;

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_origin, n_origin;
    logic [31:0]              r_span, n_span;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [31:0]              span_inc;
    logic [31:0]              pos32, origin32;

    // Result of scanning the current word from idle
    t_mode  idle_mode;
    logic   idle_tv;
    t_token idle_tok;

    // Token flushed ahead of the main one, and the main one
    logic   pre_v, main_v, do_idle;
    t_token pre_tok, main_tok;

    function automatic t_token mk(input t_kind k, input logic [31:0] s,
                                  input logic [31:0] l, input t_err e);
        t_token t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.err    = e;
        t.last   = 1'b0;
        return t;
    endfunction

    assign pos_inc  = (r_pos == '1) ? r_pos : r_pos + 1'b1;
    assign span_inc = (r_span == SPAN_MAX) ? r_span : r_span + 32'd1;
    assign pos32    = 32'(r_pos);
    assign origin32 = 32'(r_origin);

    always_comb begin
        idle_mode = M_IDLE;
        idle_tv   = 1'b0;
        idle_tok  = mk(K_ERROR, pos32, 32'd1, E_BAD_CHAR);
        if (is_space(i_char)) begin
            idle_mode = M_IDLE;
        end else if (i_char == CH_SEMI) begin
            idle_mode = M_COMMENT;
        end else if (is_init(i_char)) begin
            idle_mode = M_IDENT;
        end else if (i_char == CH_BAR) begin
            idle_mode = M_BAR;
        end else if (i_char == CH_HASH) begin
            idle_mode = M_HASH;
        end else if (i_char == CH_DQUOTE) begin
            idle_mode = M_STRING;
        end else if (i_char == CH_LPAREN) begin
            idle_tv  = 1'b1;
            idle_tok = mk(K_LPAREN, pos32, 32'd1, E_NONE);
        end else if (i_char == CH_RPAREN) begin
            idle_tv  = 1'b1;
            idle_tok = mk(K_RPAREN, pos32, 32'd1, E_NONE);
        end else if (i_char == CH_QUOTE) begin
            idle_tv  = 1'b1;
            idle_tok = mk(K_QUOTE, pos32, 32'd1, E_NONE);
        end else if (i_char == CH_BTICK) begin
            idle_tv  = 1'b1;
            idle_tok = mk(K_BACKTICK, pos32, 32'd1, E_NONE);
        end else if (i_char == CH_COMMA) begin
            idle_mode = M_COMMA;
        end else begin
            idle_tv = 1'b1;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_origin = r_origin;
        n_span   = r_span;
        pre_v    = 1'b0;
        pre_tok  = mk(K_IDENT, origin32, r_span, E_NONE);
        main_v   = 1'b0;
        main_tok = mk(K_EOF, pos32, 32'd0, E_NONE);
        do_idle  = 1'b0;
        if (r_mode == M_DONE) begin
            main_v = 1'b1;
        end else if (i_end) begin
            main_v = 1'b1;
            n_mode = M_DONE;
            case (r_mode)
                M_IDENT, M_BAR: begin
                    pre_v = 1'b1;
                end
                M_HASH: begin
                    pre_v   = 1'b1;
                    pre_tok = mk(K_ERROR, origin32, 32'd1, E_BAD_CHAR);
                end
                M_STRING: begin
                    pre_v   = 1'b1;
                    pre_tok = mk(K_ERROR, origin32, r_span, E_OPEN_STR);
                end
                M_COMMA: begin
                    pre_v   = 1'b1;
                    pre_tok = mk(K_COMMA, origin32, 32'd1, E_NONE);
                end
                default: begin
                    pre_v = 1'b0;
                end
            endcase
        end else begin
            case (r_mode)
                M_COMMENT: begin
                    if (i_char == CH_LF || i_char == CH_CR) begin
                        n_mode = M_IDLE;
                    end
                    n_pos = pos_inc;
                end
                M_IDENT: begin
                    if (is_subs(i_char)) begin
                        n_span = span_inc;
                        n_pos  = pos_inc;
                    end else begin
                        // flush the identifier, then rescan this word
                        pre_v   = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_BAR, M_STRING: begin
                    n_span = span_inc;
                    n_pos  = pos_inc;
                    if ((r_mode == M_BAR && i_char == CH_BAR) ||
                        (r_mode == M_STRING && i_char == CH_DQUOTE)) begin
                        main_v   = 1'b1;
                        main_tok = mk((r_mode == M_BAR) ? K_IDENT : K_STRING,
                                      origin32, span_inc, E_NONE);
                        n_mode   = M_IDLE;
                    end
                end
                M_HASH: begin
                    main_v = 1'b1;
                    if (i_char == CH_LOWER_T) begin
                        main_tok = mk(K_TRUE, origin32, 32'd2, E_NONE);
                    end else if (i_char == CH_LOWER_F) begin
                        main_tok = mk(K_FALSE, origin32, 32'd2, E_NONE);
                    end else begin
                        main_tok = mk(K_ERROR, origin32, 32'd2, E_BAD_CHAR);
                    end
                    n_mode = M_IDLE;
                    n_pos  = pos_inc;
                end
                M_COMMA: begin
                    if (i_char == CH_AT) begin
                        main_v   = 1'b1;
                        main_tok = mk(K_COMMA_AT, origin32, 32'd2, E_NONE);
                        n_mode   = M_IDLE;
                        n_pos    = pos_inc;
                    end else begin
                        pre_v   = 1'b1;
                        pre_tok = mk(K_COMMA, origin32, 32'd1, E_NONE);
                        do_idle = 1'b1;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase
            if (do_idle) begin
                n_mode   = idle_mode;
                n_origin = r_pos;
                n_span   = 32'd1;
                n_pos    = pos_inc;
                main_v   = idle_tv;
                main_tok = idle_tok;
            end
        end
    end

    // Order the tokens and mark the final one of this word
    always_comb begin
        o_push.count = {1'b0, pre_v} + {1'b0, main_v};
        o_push.tok0  = pre_v ? pre_tok : main_tok;
        o_push.tok1  = main_tok;
        if (pre_v && main_v) begin
            o_push.tok1.last = 1'b1;
        end else begin
            o_push.tok0.last = 1'b1;
        end
        if (!i_accept) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_origin <= '0;
            r_span   <= '0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_origin <= n_origin;
            r_span   <= n_span;
        end
    end

endmodule

// ===== src/sts_ofifo.sv =====
module sts_ofifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sts_pkg::t_push  i_push,
    input  logic            i_pop,
    output logic            o_room,
    output logic            o_valid,
    output sts_pkg::t_token o_tok
);
    import sts_pkg::*;

    localparam int unsigned PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_BITS = $clog2(FIFO_DEPTH + 1);

    t_token              r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] r_wr, r_rd;
    logic [CNT_BITS-1:0] r_cnt;
    logic [PTR_BITS-1:0] wr_next;
    logic                pop;

    assign wr_next = r_wr + 1'b1;
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];
    assign pop     = i_pop && o_valid;
    // keep space for the worst case of two tokens from one word
    assign o_room  = (r_cnt <= CNT_BITS'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.tok0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PTR_BITS'(i_push.count);
            r_rd  <= r_rd + PTR_BITS'(pop);
            r_cnt <= r_cnt + CNT_BITS'(i_push.count) - CNT_BITS'(pop);
        end
    end

endmodule

// ===== tb/scheme_token_scanner_core_tb.sv =====
`timescale 1ns / 100ps

module scheme_token_scanner_core_tb;
    import sts_pkg::*;

    localparam int          RUN_LIMIT = 1000000;
    localparam int          DRAIN     = 20;
    localparam logic [31:0] POS_TOP   = 32'hFFFF_FFFF;
    localparam string       LEAD_SET  = "abcxyzAMQZgkpt!$%&*/:<=>?^_~";
    localparam string       TAIL_SET  = "0123456789+-.@";

    typedef enum logic [2:0] {
        LX_IDLE, LX_NOTE, LX_NAME, LX_BAR, LX_HASH, LX_TEXT, LX_COMMA, LX_DONE
    } t_lex_mode;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        bit         hold;
    } t_src_word;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = 8'd0;   // [7:0] char_code
    logic        i_s_axis_tuser  = 1'b0;   // [0] end_flag
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [71:0] o_m_axis_tdata;           // [3:0] kind, [35:4] start, [67:36] length, [69:68] error
    logic        o_m_axis_tlast;

    scheme_token_scanner_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    t_src_word   chars_pending[$];
    t_token      tokens_due[$];
    t_token      batch[$];
    t_token      want;
    t_src_word   next_word;

    t_lex_mode   lex_mode   = LX_IDLE;
    logic [31:0] cur_pos    = 32'd0;
    logic [31:0] tok_org    = 32'd0;
    logic [31:0] tok_len    = 32'd0;

    int          fail_count = 0;
    int          cycle_count = 0;
    int          gap_left   = 0;
    int          stall_left = 0;
    int          words_total = 0;
    int          words_taken = 0;
    bit          tx_calm    = 1'b0;
    bit          rx_calm    = 1'b0;
    bit          hold_next  = 1'b0;
    logic        word_live;

    // ---------------- character classes ----------------

    function automatic bit blank(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit lead(input logic [7:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
            return 1'b1;
        case (c)
            "!", "$", "%", "&", "*", "/", ":", "<", "=", ">", "?", "^", "_", "~": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit follow(input logic [7:0] c);
        if (lead(c) || (c >= "0" && c <= "9"))
            return 1'b1;
        case (c)
            "+", "-", ".", "@": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // ---------------- scanner prediction ----------------

    task automatic emit_tok(input t_kind k, input logic [31:0] s, input logic [31:0] n,
                            input t_err e);
        t_token t;
        t.kind   = k;
        t.start  = s;
        t.length = n;
        t.err    = e;
        t.last   = 1'b0;
        batch.insert(batch.size(), t);
    endtask

    task automatic bump_pos();
        if (cur_pos != POS_TOP)
            cur_pos = cur_pos + 32'd1;
    endtask

    task automatic grow_tok();
        if (tok_len != SPAN_MAX)
            tok_len = tok_len + 32'd1;
    endtask

    task automatic scan_from_idle(input logic [7:0] c);
        lex_mode = LX_IDLE;
        tok_org  = cur_pos;
        tok_len  = 32'd1;
        if (blank(c)) begin
        end else if (c == CH_SEMI) begin
            lex_mode = LX_NOTE;
        end else if (lead(c)) begin
            lex_mode = LX_NAME;
        end else if (c == CH_BAR) begin
            lex_mode = LX_BAR;
        end else if (c == CH_HASH) begin
            lex_mode = LX_HASH;
        end else if (c == CH_DQUOTE) begin
            lex_mode = LX_TEXT;
        end else if (c == CH_LPAREN) begin
            emit_tok(K_LPAREN, cur_pos, 32'd1, E_NONE);
        end else if (c == CH_RPAREN) begin
            emit_tok(K_RPAREN, cur_pos, 32'd1, E_NONE);
        end else if (c == CH_QUOTE) begin
            emit_tok(K_QUOTE, cur_pos, 32'd1, E_NONE);
        end else if (c == CH_BTICK) begin
            emit_tok(K_BACKTICK, cur_pos, 32'd1, E_NONE);
        end else if (c == CH_COMMA) begin
            lex_mode = LX_COMMA;
        end else begin
            emit_tok(K_ERROR, cur_pos, 32'd1, E_BAD_CHAR);
        end
        bump_pos();
    endtask

    // Work out the tokens one accepted word produces and queue them
    task automatic lex_word(input logic [7:0] c, input logic fin);
        batch.delete();
        if (lex_mode == LX_DONE) begin
            emit_tok(K_EOF, cur_pos, 32'd0, E_NONE);
        end else if (fin) begin
            case (lex_mode)
                LX_NAME, LX_BAR: emit_tok(K_IDENT, tok_org, tok_len, E_NONE);
                LX_HASH:         emit_tok(K_ERROR, tok_org, 32'd1, E_BAD_CHAR);
                LX_TEXT:         emit_tok(K_ERROR, tok_org, tok_len, E_OPEN_STR);
                LX_COMMA:        emit_tok(K_COMMA, tok_org, 32'd1, E_NONE);
                default: ;
            endcase
            emit_tok(K_EOF, cur_pos, 32'd0, E_NONE);
            lex_mode = LX_DONE;
        end else begin
            case (lex_mode)
                LX_NOTE: begin
                    if (c == CH_LF || c == CH_CR)
                        lex_mode = LX_IDLE;
                    bump_pos();
                end
                LX_NAME: begin
                    if (follow(c)) begin
                        grow_tok();
                        bump_pos();
                    end else begin
                        emit_tok(K_IDENT, tok_org, tok_len, E_NONE);
                        scan_from_idle(c);
                    end
                end
                LX_BAR: begin
                    grow_tok();
                    bump_pos();
                    if (c == CH_BAR) begin
                        emit_tok(K_IDENT, tok_org, tok_len, E_NONE);
                        lex_mode = LX_IDLE;
                    end
                end
                LX_HASH: begin
                    if (c == CH_LOWER_T)
                        emit_tok(K_TRUE, tok_org, 32'd2, E_NONE);
                    else if (c == CH_LOWER_F)
                        emit_tok(K_FALSE, tok_org, 32'd2, E_NONE);
                    else
                        emit_tok(K_ERROR, tok_org, 32'd2, E_BAD_CHAR);
                    lex_mode = LX_IDLE;
                    bump_pos();
                end
                LX_TEXT: begin
                    grow_tok();
                    bump_pos();
                    if (c == CH_DQUOTE) begin
                        emit_tok(K_STRING, tok_org, tok_len, E_NONE);
                        lex_mode = LX_IDLE;
                    end
                end
                LX_COMMA: begin
                    if (c == CH_AT) begin
                        emit_tok(K_COMMA_AT, tok_org, 32'd2, E_NONE);
                        lex_mode = LX_IDLE;
                        bump_pos();
                    end else begin
                        emit_tok(K_COMMA, tok_org, 32'd1, E_NONE);
                        scan_from_idle(c);
                    end
                end
                default: scan_from_idle(c);
            endcase
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            tokens_due.insert(tokens_due.size(), batch[i]);
    endtask

    // ---------------- stimulus helpers ----------------

    task automatic put_word(input logic [7:0] c, input logic fin);
        t_src_word w;
        w.ch   = c;
        w.fin  = fin;
        w.hold = hold_next;
        hold_next = 1'b0;
        chars_pending.insert(chars_pending.size(), w);
    endtask

    task automatic put_char(input logic [7:0] c);
        put_word(c, 1'b0);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    function automatic logic [7:0] pick(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == a || c == b)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] space_char();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(9, 13)) : 8'd32;
    endfunction

    function automatic int body_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
    endfunction

    // One well-formed lexeme with random content, or a stray byte now and then
    task automatic add_lexeme();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = body_len();
        if (r < 25) begin
            put_char(pick(LEAD_SET));
            repeat (n)
                put_char(($urandom_range(0, 2) == 0) ? pick(TAIL_SET) : pick(LEAD_SET));
        end else if (r < 30) begin
            put_char(CH_BAR);
            repeat (n) put_char(any_but(CH_BAR, CH_BAR));
            put_char(CH_BAR);
        end else if (r < 37) begin
            put_char(CH_DQUOTE);
            repeat (n) put_char(any_but(CH_DQUOTE, CH_DQUOTE));
            put_char(CH_DQUOTE);
        end else if (r < 43) begin
            put_char(CH_HASH);
            put_char($urandom_range(0, 1) ? CH_LOWER_T : CH_LOWER_F);
        end else if (r < 53) begin
            put_char($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
        end else if (r < 57) begin
            put_char(CH_QUOTE);
        end else if (r < 61) begin
            put_char(CH_BTICK);
        end else if (r < 65) begin
            put_char(CH_COMMA);
        end else if (r < 68) begin
            put_char(CH_COMMA);
            put_char(CH_AT);
        end else if (r < 72) begin
            put_char(CH_SEMI);
            repeat (n) put_char(any_but(CH_LF, CH_CR));
            put_char($urandom_range(0, 1) ? CH_LF : CH_CR);
        end else if (r < 85) begin
            put_char(space_char());
        end else if (r < 92) begin
            put_char(8'($urandom_range(0, 255)));
        end else if (r < 96) begin
            put_char(CH_HASH);
            put_char(8'($urandom_range(0, 255)));
        end else begin
            put_char(CH_COMMA);
            put_char(8'($urandom_range(0, 255)));
        end
        // leave out the separator often so that tokens abut
        if ($urandom_range(0, 9) < 6)
            put_char(space_char());
    endtask

    function automatic int sender_gap();
        int r;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        if (tx_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int receiver_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ---------------- clock, reset, run control ----------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        // directed: every token kind, identifier and comma flushed by the next
        // character, bad character after hash, and both ends of the byte range
        put_text("(ab)#t#f,@,(\"s\"|x|'");
        put_char(CH_BTICK);
        put_text("#q;c");
        put_char(CH_LF);
        put_char(8'hFF);
        put_char(8'h00);

        hold_next = 1'b1;
        while (chars_pending.size() < 1100) begin
            if (chars_pending.size() > 600 && chars_pending.size() < 640)
                hold_next = 1'b1;
            add_lexeme();
        end

        // close any comment, then usually leave one construct open when input ends
        put_char(CH_LF);
        case ($urandom_range(0, 6))
            0: put_text("\"ab");
            1: put_text("|q");
            2: put_text("zz");
            3: put_char(CH_COMMA);
            4: put_text(";x");
            5: put_char(CH_HASH);
            default: ;
        endcase
        put_word(8'($urandom_range(0, 255)), 1'b1);
        repeat ($urandom_range(3, 6))
            put_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        words_total = chars_pending.size();

        @(posedge i_clk);
        while (words_taken < words_total || tokens_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0)
            $display("scheme_token_scanner_core: match");
        else
            $display("scheme_token_scanner_core: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("scheme_token_scanner_core: mismatch");
            $finish;
        end
    end

    // ---------------- source side ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            word_live = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                lex_word(i_s_axis_tdata, i_s_axis_tuser);
                words_taken++;
                word_live = 1'b0;
            end
            if (!word_live) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (chars_pending.size() > 0 &&
                             !(chars_pending[0].hold && tokens_due.size() > 0)) begin
                    next_word = chars_pending[0];
                    chars_pending.delete(0);
                    i_s_axis_tdata <= next_word.ch;
                    i_s_axis_tuser <= next_word.fin;
                    word_live = 1'b1;
                    gap_left = sender_gap();
                end
            end
            i_s_axis_tvalid <= word_live;
        end
    end

    // ---------------- token side ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (stall_left > 0)
                stall_left--;
            else if ($urandom_range(0, 299) == 0)
                rx_calm = !rx_calm;
            else if (!rx_calm && $urandom_range(0, 99) < 12)
                stall_left = receiver_stall();
            i_m_axis_tready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (tokens_due.size() == 0) begin
                $error("token with none outstanding: kind %0d start %0d",
                       o_m_axis_tdata[3:0], o_m_axis_tdata[35:4]);
                fail_count++;
            end else begin
                want = tokens_due[0];
                tokens_due.delete(0);
                if (o_m_axis_tdata[3:0] !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, o_m_axis_tdata[3:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[35:4] !== want.start) begin
                    $error("token_start: expected %0d, got %0d", want.start,
                           o_m_axis_tdata[35:4]);
                    fail_count++;
                end
                if (o_m_axis_tdata[67:36] !== want.length) begin
                    $error("token_length: expected %0d, got %0d", want.length,
                           o_m_axis_tdata[67:36]);
                    fail_count++;
                end
                if (o_m_axis_tdata[69:68] !== want.err) begin
                    $error("error_code: expected %0d, got %0d", want.err, o_m_axis_tdata[69:68]);
                    fail_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last_flag: expected %0d, got %0d", want.last, o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

endmodule

// ===== filelist.f =====
src/sts_pkg.sv
src/sts_scan.sv
src/sts_ofifo.sv
src/scheme_token_scanner_core.sv
tb/scheme_token_scanner_core_tb.sv
